// ===== rtl/spqr_pkg.sv =====
// Shared types, codes and helpers of the signal priority queue with registry.
package spqr_pkg;

  // Operation codes of an input item
  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_POST     = 2'd1,
    OP_RECEIVE  = 2'd2,
    OP_NOP      = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_BAD_ID   = 3'd1,
    STATUS_FULL     = 3'd2,
    STATUS_EMPTY    = 3'd3,
    STATUS_DETACHED = 3'd4
  } status_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PRIORITY_MODE = 2'd0,
    CFG_ACTIVE_SLOTS  = 2'd1,
    CFG_ATTACHED      = 2'd2
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_APPLY
  } state_e;

  localparam int unsigned CfgDataWidth = 6;
  localparam int unsigned CountOutWidth = 6;

  // Per-cell queue control
  typedef struct packed {
    logic clr;        // drop the entry
    logic load;       // take the new item
    logic take_prev;  // take the entry of the cell in front
    logic take_next;  // take the entry of the cell behind
  } qcell_ctl_t;

  // Slot counts that a configuration write may select
  function automatic logic slots_legal(input logic [CfgDataWidth-1:0] v);
    logic ok;
    ok = (v == 6'd1) || (v == 6'd4) || (v == 6'd8) || (v == 6'd16) ||
         (v == 6'd24) || (v == 6'd32);
    return ok;
  endfunction

endpackage

// ===== rtl/spqr_qcell.sv =====
// One queue cell: holds one posted signal and moves it up or down the chain.
module spqr_qcell
  import spqr_pkg::*;
#(
  parameter int unsigned ID_WIDTH      = 8,
  parameter int unsigned INFO_WIDTH    = 32,
  parameter int unsigned HANDLER_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  qcell_ctl_t               ctl_i,
  input  logic [ID_WIDTH-1:0]      key_i,
  input  logic [INFO_WIDTH-1:0]    new_info_i,
  input  logic [HANDLER_WIDTH-1:0] new_handler_i,
  input  logic                     prev_valid_i,
  input  logic [ID_WIDTH-1:0]      prev_id_i,
  input  logic [INFO_WIDTH-1:0]    prev_info_i,
  input  logic [HANDLER_WIDTH-1:0] prev_handler_i,
  input  logic                     next_valid_i,
  input  logic [ID_WIDTH-1:0]      next_id_i,
  input  logic [INFO_WIDTH-1:0]    next_info_i,
  input  logic [HANDLER_WIDTH-1:0] next_handler_i,
  output logic                     valid_o,
  output logic [ID_WIDTH-1:0]      id_o,
  output logic [INFO_WIDTH-1:0]    info_o,
  output logic [HANDLER_WIDTH-1:0] handler_o,
  output logic                     gt_o
);

  logic                     valid_q;
  logic [ID_WIDTH-1:0]      id_q;
  logic [INFO_WIDTH-1:0]    info_q;
  logic [HANDLER_WIDTH-1:0] handler_q;

  // Occupancy bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.clr) begin
      valid_q <= 1'b0;
    end else if (ctl_i.load) begin
      valid_q <= 1'b1;
    end else if (ctl_i.take_prev) begin
      valid_q <= prev_valid_i;
    end else if (ctl_i.take_next) begin
      valid_q <= next_valid_i;
    end
  end

  // Entry payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr) begin
      id_q      <= '0;
      info_q    <= '0;
      handler_q <= '0;
    end else if (ctl_i.load) begin
      id_q      <= key_i;
      info_q    <= new_info_i;
      handler_q <= new_handler_i;
    end else if (ctl_i.take_prev) begin
      id_q      <= prev_id_i;
      info_q    <= prev_info_i;
      handler_q <= prev_handler_i;
    end else if (ctl_i.take_next) begin
      id_q      <= next_id_i;
      info_q    <= next_info_i;
      handler_q <= next_handler_i;
    end
  end

  // Flag an occupied entry that a new id would go in front of
  assign gt_o      = valid_q && (id_q > key_i);
  assign valid_o   = valid_q;
  assign id_o      = id_q;
  assign info_o    = info_q;
  assign handler_o = handler_q;

endmodule

// ===== rtl/spqr_rcell.sv =====
// One registry cell: a signal id bound to a handler token.
module spqr_rcell
  import spqr_pkg::*;
#(
  parameter int unsigned ID_WIDTH      = 8,
  parameter int unsigned HANDLER_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic [ID_WIDTH-1:0]      key_i,
  input  logic                     we_i,
  input  logic [ID_WIDTH-1:0]      wr_id_i,
  input  logic [HANDLER_WIDTH-1:0] wr_handler_i,
  output logic                     match_o,
  output logic                     free_o,
  output logic [HANDLER_WIDTH-1:0] handler_o
);

  logic [ID_WIDTH-1:0]      id_q;
  logic [HANDLER_WIDTH-1:0] handler_q;

  // Binding, zero id marks a free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q      <= '0;
      handler_q <= '0;
    end else if (we_i) begin
      id_q      <= wr_id_i;
      handler_q <= wr_handler_i;
    end
  end

  // Compare against the key, only inside the usable range
  assign match_o   = en_i && (id_q == key_i);
  assign free_o    = en_i && (id_q == '0);
  assign handler_o = handler_q;

endmodule

// ===== rtl/signal_priority_queue_with_registry.sv =====
// Top level: signal queue as a chain of cells plus a handler registry.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------------
//  input    | in_valid_i / in_stall_o | op_i, signal_id_i, handler_token_i,
//           |                         | info_value_i
//  result   | out_valid_o/out_stall_i | status_o, out_id_o, out_info_o,
//           |                         | out_handler_o, queue_count_o
//  config   | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Each item passes through these steps: transfer into the item register, the
// evaluate state in which every queue and registry cell compares its entry with
// the id, and the apply state in which the first-hit masks steer the shifts and writes of the cells.
// The apply cycle waits while the previous result is still stalled.
// Reset empties the queue and frees the registry; there is no clearing pass.
// Configuration writes always transfer; the user must issue them only while idle, the block does not enforce it.
module signal_priority_queue_with_registry
  import spqr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH   = 32,
  parameter int unsigned ID_WIDTH      = 8,
  parameter int unsigned INFO_WIDTH    = 32,
  parameter int unsigned HANDLER_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input items
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               op_i,
  input  logic [ID_WIDTH-1:0]      signal_id_i,
  input  logic [HANDLER_WIDTH-1:0] handler_token_i,
  input  logic [INFO_WIDTH-1:0]    info_value_i,
  // results
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               status_o,
  output logic [ID_WIDTH-1:0]      out_id_o,
  output logic [INFO_WIDTH-1:0]    out_info_o,
  output logic [HANDLER_WIDTH-1:0] out_handler_o,
  output logic [CountOutWidth-1:0] queue_count_o,
  // configuration writes
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i
);

  localparam int unsigned QD   = QUEUE_DEPTH;
  localparam int unsigned CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > CfgDataWidth) ? CW : CfgDataWidth;
  localparam logic [CfgDataWidth-1:0] SLOTS_RST =
      CfgDataWidth'((QUEUE_DEPTH < 32) ? QUEUE_DEPTH : 32);

  // ---------------------------------------------------------------------------
  // Control and configuration registers
  state_e state_q, state_d;

  op_e                      op_q;
  logic [ID_WIDTH-1:0]      id_q;
  logic [HANDLER_WIDTH-1:0] tok_q;
  logic [INFO_WIDTH-1:0]    info_q;

  logic                     prio_q;
  logic [CfgDataWidth-1:0]  slots_q;
  logic                     attached_q;
  logic [CW-1:0]            count_q, count_d;

  logic [QD-1:0] match_q, free_q, gt_q;

  logic                     out_valid_q;
  logic [2:0]               status_q;
  logic [ID_WIDTH-1:0]      rid_q;
  logic [INFO_WIDTH-1:0]    rinfo_q;
  logic [HANDLER_WIDTH-1:0] rtok_q;

  logic accept, eval_en, fire, cfg_wr, cfg_clear;

  // Cell chain signals
  qcell_ctl_t               qctl   [QD];
  logic                     qvalid [QD];
  logic [ID_WIDTH-1:0]      qid    [QD];
  logic [INFO_WIDTH-1:0]    qinfo  [QD];
  logic [HANDLER_WIDTH-1:0] qhand  [QD];
  logic [QD-1:0]            qgt, qvalid_v;

  logic [QD-1:0]            rmatch, rfree, ren, rwe;
  logic [HANDLER_WIDTH-1:0] rhand  [QD];
  logic [ID_WIDTH-1:0]      rwr_id;
  logic [HANDLER_WIDTH-1:0] rwr_hand;

  // Apply-cycle decode
  logic [QD-1:0]            m_first, f_first, pos_oh, after_pos;
  logic [QD-1:0]            q_load, q_up, q_down;
  logic [HANDLER_WIDTH-1:0] lookup_tok;
  logic                     full;
  status_e                  status_d;
  logic [ID_WIDTH-1:0]      rid_d;
  logic [INFO_WIDTH-1:0]    rinfo_d;
  logic [HANDLER_WIDTH-1:0] rtok_d;

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_EVAL;
      ST_EVAL:  state_d = ST_APPLY;
      ST_APPLY: if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_stall_o = 1'b1;
    eval_en    = 1'b0;
    fire       = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_stall_o = 1'b0;
      ST_EVAL:  eval_en = 1'b1;
      ST_APPLY: fire = !out_valid_q || !out_stall_i;
      default:  in_stall_o = 1'b1;
    endcase
  end

  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_clear   = cfg_wr && (cfg_index_i == CFG_ATTACHED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(op_i);
      id_q   <= signal_id_i;
      tok_q  <= handler_token_i;
      info_q <= info_value_i;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_q     <= 1'b1;
      slots_q    <= SLOTS_RST;
      attached_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        CFG_PRIORITY_MODE: prio_q <= cfg_data_i[0];
        CFG_ACTIVE_SLOTS: begin
          if (slots_legal(cfg_data_i) && (CMPW'(cfg_data_i) <= CMPW'(QUEUE_DEPTH))) begin
            slots_q <= cfg_data_i;
          end
        end
        CFG_ATTACHED:      attached_q <= cfg_data_i[0];
        default:           prio_q <= prio_q;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Usable slot range
  always_comb begin
    for (int i = 0; i < QD; i++) begin
      ren[i] = CMPW'(i) < CMPW'(slots_q);
    end
  end

  // Latch the compare vectors of all cells
  always_ff @(posedge clk_i) begin
    if (eval_en) begin
      match_q <= rmatch;
      free_q  <= rfree;
      gt_q    <= prio_q ? (qgt | ~qvalid_v) : ~qvalid_v;
    end
  end

  // ---------------------------------------------------------------------------
  // First-hit masks and handler lookup
  always_comb begin
    m_first   = match_q & (~match_q + QD'(1));
    f_first   = free_q & (~free_q + QD'(1));
    pos_oh    = gt_q & (~gt_q + QD'(1));
    after_pos = (~pos_oh + QD'(1)) & ~pos_oh;
    lookup_tok = '0;
    for (int i = 0; i < QD; i++) begin
      lookup_tok = lookup_tok | (m_first[i] ? rhand[i] : '0);
    end
  end

  assign full = CMPW'(count_q) >= CMPW'(slots_q);

  // Decode the operation in the apply cycle
  always_comb begin
    status_d = STATUS_OK;
    rid_d    = '0;
    rinfo_d  = '0;
    rtok_d   = '0;
    rwe      = '0;
    rwr_id   = id_q;
    rwr_hand = tok_q;
    q_load   = '0;
    q_up     = '0;
    q_down   = '0;
    count_d  = count_q;
    unique case (op_q)
      OP_REGISTER: begin
        if (id_q == '0) begin
          status_d = STATUS_BAD_ID;
        end else if (|match_q) begin
          rwe    = m_first;
          rwr_id = (tok_q == '0) ? '0 : id_q;
        end else if (tok_q == '0) begin
          status_d = STATUS_OK;
        end else if (free_q == '0) begin
          status_d = STATUS_FULL;
        end else begin
          rwe = f_first;
        end
      end
      OP_POST: begin
        if (id_q == '0) begin
          status_d = STATUS_BAD_ID;
        end else if (!attached_q) begin
          status_d = STATUS_DETACHED;
        end else if (full) begin
          status_d = STATUS_FULL;
        end else begin
          q_load  = pos_oh;
          q_up    = after_pos;
          count_d = count_q + CW'(1);
        end
      end
      OP_RECEIVE: begin
        if (!attached_q) begin
          status_d = STATUS_DETACHED;
        end else if (count_q == '0) begin
          status_d = STATUS_EMPTY;
        end else begin
          rid_d   = qid[0];
          rinfo_d = qinfo[0];
          rtok_d  = qhand[0];
          q_down  = '1;
          count_d = count_q - CW'(1);
        end
      end
      OP_NOP:  status_d = STATUS_OK;
      default: status_d = STATUS_OK;
    endcase
  end

  // Entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_clear) begin
      count_q <= '0;
    end else if (fire) begin
      count_q <= count_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      rid_q    <= rid_d;
      rinfo_q  <= rinfo_d;
      rtok_q   <= rtok_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_id_o      = rid_q;
  assign out_info_o    = rinfo_q;
  assign out_handler_o = rtok_q;
  assign queue_count_o = CountOutWidth'(CMPW'(count_q));

  // ---------------------------------------------------------------------------
  // Queue chain and registry cells
  for (genvar g = 0; g < QD; g++) begin : g_cell
    logic                     pv, nv;
    logic [ID_WIDTH-1:0]      pid, nid;
    logic [INFO_WIDTH-1:0]    pinfo, ninfo;
    logic [HANDLER_WIDTH-1:0] phand, nhand;

    if (g == 0) begin : g_head
      assign pv    = 1'b0;
      assign pid   = '0;
      assign pinfo = '0;
      assign phand = '0;
    end else begin : g_mid
      assign pv    = qvalid[g-1];
      assign pid   = qid[g-1];
      assign pinfo = qinfo[g-1];
      assign phand = qhand[g-1];
    end

    if (g == QD - 1) begin : g_tail
      assign nv    = 1'b0;
      assign nid   = '0;
      assign ninfo = '0;
      assign nhand = '0;
    end else begin : g_body
      assign nv    = qvalid[g+1];
      assign nid   = qid[g+1];
      assign ninfo = qinfo[g+1];
      assign nhand = qhand[g+1];
    end

    // Steer this cell: clear on attach write, else follow the apply decode
    always_comb begin
      qctl[g].clr       = cfg_clear;
      qctl[g].load      = fire && q_load[g];
      qctl[g].take_prev = fire && q_up[g];
      qctl[g].take_next = fire && q_down[g];
    end

    spqr_qcell #(
      .ID_WIDTH      (ID_WIDTH),
      .INFO_WIDTH    (INFO_WIDTH),
      .HANDLER_WIDTH (HANDLER_WIDTH)
    ) u_qcell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctl_i          (qctl[g]),
      .key_i          (id_q),
      .new_info_i     (info_q),
      .new_handler_i  (lookup_tok),
      .prev_valid_i   (pv),
      .prev_id_i      (pid),
      .prev_info_i    (pinfo),
      .prev_handler_i (phand),
      .next_valid_i   (nv),
      .next_id_i      (nid),
      .next_info_i    (ninfo),
      .next_handler_i (nhand),
      .valid_o        (qvalid[g]),
      .id_o           (qid[g]),
      .info_o         (qinfo[g]),
      .handler_o      (qhand[g]),
      .gt_o           (qgt[g])
    );

    assign qvalid_v[g] = qvalid[g];

    spqr_rcell #(
      .ID_WIDTH      (ID_WIDTH),
      .HANDLER_WIDTH (HANDLER_WIDTH)
    ) u_rcell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .en_i         (ren[g]),
      .key_i        (id_q),
      .we_i         (fire && rwe[g]),
      .wr_id_i      (rwr_id),
      .wr_handler_i (rwr_hand),
      .match_o      (rmatch[g]),
      .free_o       (rfree[g]),
      .handler_o    (rhand[g])
    );
  end

endmodule
